FILE: hw/rtl/psh_pkg.sv
package psh_pkg;

    // field and register widths
    localparam int ACC_W      = 64;
    localparam int RADIX_W    = 63;
    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int HASH_B_W   = 63;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;

    // iteration counts: two radix bits per multiply step, one bit per reduce step
    localparam int MUL_STEPS  = ACC_W / 2;
    localparam int MOD_STEPS  = ACC_W;
    localparam int CNT_W      = $clog2(MOD_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_B = 2'd3;

    // reset values
    localparam logic [MODE_W-1:0]  RST_HASH_MODE = 2'd1;
    localparam logic [RADIX_W-1:0] RST_RADIX     = 63'd131;
    localparam logic [RADIX_W-1:0] RST_MODULUS_A = 63'd19260817;
    localparam logic [RADIX_W-1:0] RST_MODULUS_B = 63'd19660813;

    // natural overflow result mask
    localparam logic [ACC_W-1:0] MASK31 = 64'h0000_0000_7fff_ffff;

    // hash modes
    localparam logic [MODE_W-1:0] MODE_NATURAL = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_MOD,
        ST_COMMIT
    } psh_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_ADD,
        OP_MOD,
        OP_COMMIT
    } lane_op_t;

    typedef struct packed {
        lane_op_t op;
        logic     load_result;
    } psh_cmd_t;

endpackage

FILE: hw/rtl/psh_lane.sv
module psh_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psh_pkg::lane_op_t             op,
    input  logic                          enable,
    input  logic                          reduce,
    input  logic                          clear,
    input  logic [psh_pkg::RADIX_W-1:0]   radix,
    input  logic [psh_pkg::RADIX_W-1:0]   modulus,
    input  logic [psh_pkg::BYTE_W-1:0]    byte_value,
    output logic [psh_pkg::ACC_W-1:0]     result
);
    import psh_pkg::*;

    logic [ACC_W-1:0]  accum_reg, accum_next;
    logic [ACC_W-1:0]  acc3_reg, acc3_next;
    logic [ACC_W-1:0]  rad_sh_reg, rad_sh_next;
    logic [ACC_W-1:0]  prod_reg, prod_next;
    logic [ACC_W-1:0]  val_reg, val_next;
    logic [ACC_W-1:0]  sh_reg, sh_next;
    logic [ACC_W-1:0]  rem_reg, rem_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;

    logic [ACC_W-1:0] digit_mult;
    logic [ACC_W-1:0] rem_trial;
    logic [ACC_W-1:0] mod_ext;
    logic             use_rem;

    assign mod_ext   = {1'b0, modulus};
    assign rem_trial = {rem_reg[ACC_W-2:0], sh_reg[ACC_W-1]};
    assign use_rem   = reduce && (modulus != '0);
    assign result    = use_rem ? rem_reg : val_reg;

    // partial product for the top two radix bits
    always_comb begin
        case (rad_sh_reg[ACC_W-1:ACC_W-2])
            2'd0:    digit_mult = '0;
            2'd1:    digit_mult = accum_reg;
            2'd2:    digit_mult = {accum_reg[ACC_W-2:0], 1'b0};
            2'd3:    digit_mult = acc3_reg;
            default: digit_mult = '0;
        endcase
    end

    // one step of load, multiply, add, reduce or commit per cycle
    always_comb begin
        accum_next  = accum_reg;
        acc3_next   = acc3_reg;
        rad_sh_next = rad_sh_reg;
        prod_next   = prod_reg;
        val_next    = val_reg;
        sh_next     = sh_reg;
        rem_next    = rem_reg;
        byte_next   = byte_reg;
        case (op)
            OP_LOAD: begin
                byte_next   = byte_value;
                acc3_next   = accum_reg + {accum_reg[ACC_W-2:0], 1'b0};
                rad_sh_next = {1'b0, radix};
                prod_next   = '0;
            end
            OP_MUL: begin
                prod_next   = {prod_reg[ACC_W-3:0], 2'b00} + digit_mult;
                rad_sh_next = {rad_sh_reg[ACC_W-3:0], 2'b00};
            end
            OP_ADD: begin
                val_next = prod_reg + {{(ACC_W-BYTE_W){1'b0}}, byte_reg};
                sh_next  = prod_reg + {{(ACC_W-BYTE_W){1'b0}}, byte_reg};
                rem_next = '0;
            end
            OP_MOD: begin
                // restoring remainder, one dividend bit per step
                rem_next = (rem_trial >= mod_ext) ? (rem_trial - mod_ext) : rem_trial;
                sh_next  = {sh_reg[ACC_W-2:0], 1'b0};
            end
            OP_COMMIT: begin
                if (clear) begin
                    accum_next = '0;
                end else if (enable) begin
                    accum_next = result;
                end
            end
            default: begin
            end
        endcase
    end

    // accumulator clears at reset, the work registers carry payload only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
        end else begin
            accum_reg <= accum_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc3_reg   <= acc3_next;
        rad_sh_reg <= rad_sh_next;
        prod_reg   <= prod_next;
        val_reg    <= val_next;
        sh_reg     <= sh_next;
        rem_reg    <= rem_next;
        byte_reg   <= byte_next;
    end

endmodule

FILE: hw/rtl/psh_datapath.sv
module psh_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  psh_pkg::psh_cmd_t                 cmd,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [psh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [psh_pkg::BYTE_W-1:0]        byte_value,
    input  logic                              end_of_string,
    output logic [psh_pkg::ACC_W-1:0]         hash_a,
    output logic [psh_pkg::HASH_B_W-1:0]      hash_b
);
    import psh_pkg::*;

    logic [MODE_W-1:0]   hash_mode_reg;
    logic [RADIX_W-1:0]  radix_reg;
    logic [RADIX_W-1:0]  modulus_a_reg;
    logic [RADIX_W-1:0]  modulus_b_reg;
    logic                natural_reg;
    logic                dbl_reg;
    logic                last_reg;
    logic [ACC_W-1:0]    hash_a_reg;
    logic [HASH_B_W-1:0] hash_b_reg;
    logic [ACC_W-1:0]    res_a;
    logic [ACC_W-1:0]    res_b;

    assign last   = last_reg;
    assign hash_a = hash_a_reg;
    assign hash_b = hash_b_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_mode_reg <= RST_HASH_MODE;
            radix_reg     <= RST_RADIX;
            modulus_a_reg <= RST_MODULUS_A;
            modulus_b_reg <= RST_MODULUS_B;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HASH_MODE: hash_mode_reg <= cfg_wdata[MODE_W-1:0];
                REG_RADIX:     radix_reg     <= cfg_wdata;
                REG_MODULUS_A: modulus_a_reg <= cfg_wdata;
                REG_MODULUS_B: modulus_b_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // mode and end mark captured with the byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            natural_reg <= 1'b0;
            dbl_reg     <= 1'b0;
            last_reg    <= 1'b0;
        end else if (cmd.op == OP_LOAD) begin
            natural_reg <= (hash_mode_reg == MODE_NATURAL);
            dbl_reg     <= hash_mode_reg[1];
            last_reg    <= end_of_string;
        end
    end

    psh_lane u_lane_a (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (cmd.op),
        .enable     (1'b1),
        .reduce     (!natural_reg),
        .clear      (last_reg),
        .radix      (radix_reg),
        .modulus    (modulus_a_reg),
        .byte_value (byte_value),
        .result     (res_a)
    );

    psh_lane u_lane_b (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (cmd.op),
        .enable     (dbl_reg),
        .reduce     (1'b1),
        .clear      (last_reg),
        .radix      (radix_reg),
        .modulus    (modulus_b_reg),
        .byte_value (byte_value),
        .result     (res_b)
    );

    // result register, loaded when the final byte commits
    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            hash_a_reg <= natural_reg ? (res_a & MASK31) : res_a;
            hash_b_reg <= dbl_reg ? res_b[HASH_B_W-1:0] : '0;
        end
    end

endmodule

FILE: hw/rtl/psh_ctrl.sv
module psh_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic                last,
    output psh_pkg::psh_cmd_t   cmd
);
    import psh_pkg::*;

    psh_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_full;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_full = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // sequencer: load, multiply steps, add byte, reduce steps, commit
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd.op          = OP_NONE;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.op   = OP_MUL;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.op     = OP_ADD;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                cmd.op   = OP_MOD;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MOD_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // a final byte waits here until the result register is free
                if (!(last && out_full)) begin
                    cmd.op          = OP_COMMIT;
                    cmd.load_result = last;
                    state_next      = ST_IDLE;
                    if (last) begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/polynomial_string_hash.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------
// s_       | in        | s_valid / s_ready  | s_byte_value, s_end_of_string
// m_       | out       | m_valid / m_ready  | m_hash_a, m_hash_b
// cfg_     | in        | cfg_we             | cfg_index, cfg_wdata
//
// each byte runs through a load step, 32 multiply steps (two radix bits a
// step), one add of the byte, 64 restoring reduce steps (one bit a step)
// and a commit step before the next byte can be taken
// both accumulators run side by side in their own lanes
// reset (synchronous, active low) clears the accumulators and loads defaults
// a final byte holds in commit while the previous result has not been taken;
// the next byte is taken while a finished result waits in the output register
module polynomial_string_hash (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [psh_pkg::BYTE_W-1:0]        s_byte_value,
    input  logic                              s_end_of_string,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [psh_pkg::ACC_W-1:0]         m_hash_a,
    output logic [psh_pkg::HASH_B_W-1:0]      m_hash_b,
    input  logic                              cfg_we,
    input  logic [psh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psh_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import psh_pkg::*;

    psh_cmd_t cmd;
    logic     last;

    psh_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .last   (last),
        .cmd    (cmd)
    );

    psh_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .byte_value   (s_byte_value),
        .end_of_string(s_end_of_string),
        .hash_a       (m_hash_a),
        .hash_b       (m_hash_b)
    );

endmodule

FILE: hw/rtl/psh_checker.sv
module psh_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [psh_pkg::ACC_W-1:0]         m_hash_a,
    input  logic [psh_pkg::HASH_B_W-1:0]      m_hash_b
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_a) && $stable(m_hash_b))
        else $error("result changed or dropped while stalled");

    // one byte at a time: no transfer in the cycle after a transfer
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a byte is still at work");

    // a byte still has its multiply and reduce steps to run, so no new result shows right after a transfer
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared right after an input transfer");

    // reset leaves the block ready and empty
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind polynomial_string_hash psh_checker u_psh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_hash_a(m_hash_a),
    .m_hash_b(m_hash_b)
);
